/* src/rth_pkg.sv */
// ----------------------------------------------------------------------------
// rth_pkg: shared types and constants for the RGB to HSV converter
// Pipeline stage records, conversion constants and one restoring-division step.
// ----------------------------------------------------------------------------
package rth_pkg;

   // Pipeline shape: input slot, prep slot, four division slots, output slot
   localparam int PipeDepth  = 7;
   localparam int DivFirst   = 2;
   localparam int DivLast    = 5;

   // Conversion constants
   localparam logic [7:0] HueRed    = 8'd0;
   localparam logic [7:0] HueGreen  = 8'd85;
   localparam logic [7:0] HueBlue   = 8'd171;
   localparam logic [7:0] HueGain   = 8'd43;
   localparam logic [7:0] SatGain   = 8'd255;

   // Captured input pixel
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pix_type;

   // Division stage record: two dividers running side by side
   typedef struct packed {
      logic [7:0]  hue_base;
      logic        hue_neg;
      logic [15:0] hue_rem;
      logic [7:0]  hue_den;
      logic [7:0]  hue_quo;
      logic [15:0] sat_rem;
      logic [7:0]  sat_den;
      logic [7:0]  sat_quo;
      logic [7:0]  brightness;
   } div_stage_type;

   // Result of one division step
   typedef struct packed {
      logic [15:0] rem;
      logic        quo_bit;
   } step_type;

   // One restoring step: try to take den << shamt out of the remainder
   function automatic step_type div_step(input logic [15:0] rem,
                                         input logic [7:0]  den,
                                         input logic [2:0]  shamt);
      logic [15:0] trial;
      step_type    res;
      trial = {8'b0, den} << shamt;
      if (rem >= trial) begin
         res.rem     = rem - trial;
         res.quo_bit = 1'b1;
      end else begin
         res.rem     = rem;
         res.quo_bit = 1'b0;
      end
      return res;
   endfunction

endpackage

/* src/rgb_to_hsv.sv */
// ----------------------------------------------------------------------------
// rgb_to_hsv: pipelined 8-bit RGB to HSV pixel converter
// Value is the largest channel, saturation 255*range/max, hue a sector base
// plus 43*difference/range; both quotients come from restoring dividers.
// ----------------------------------------------------------------------------
//
//   channel  ports                                  direction
//   req      req_valid req_ready req_red/green/blue  in  (one pixel per item)
//   rsp      rsp_valid rsp_ready rsp_hue/            out (one result per item)
//            rsp_saturation rsp_brightness
//
// One item enters per cycle unless the pipeline is stalled. The depth is
// set by the two 8-bit restoring dividers, run two quotient bits per stage
// over four stages, behind an input and a prep stage. Reset clears all
// valid bits. Each stage holds its item while the next stage is full and
// stalled, so empty stages still fill while a result waits.
//
module rgb_to_hsv (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_hue,
   output logic [7:0] rsp_saturation,
   output logic [7:0] rsp_brightness
);
   import rth_pkg::*;

   logic [PipeDepth-1:0] valid_ff;
   logic [PipeDepth-1:0] valid_in;
   logic [PipeDepth-1:0] rdy;

   pix_type       pix_ff;
   pix_type       pix_in;
   div_stage_type prep_in;
   div_stage_type div_ff [1:DivLast];
   div_stage_type div_in [DivFirst:DivLast];
   logic [7:0]    hue_ff;
   logic [7:0]    hue_in;
   logic [7:0]    sat_ff;
   logic [7:0]    sat_in;
   logic [7:0]    bright_ff;
   logic [7:0]    bright_in;

   // Slot ready: empty, or its item moves on this cycle
   always_comb begin
      rdy[PipeDepth-1] = !valid_ff[PipeDepth-1] || rsp_ready;
      for (int k = PipeDepth - 2; k >= 0; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
   end

   assign req_ready = rdy[0];

   // Advance valid bits slot by slot
   always_comb begin
      if (rdy[0]) begin
         valid_in[0] = req_valid;
      end else begin
         valid_in[0] = valid_ff[0];
      end
      for (int k = 1; k < PipeDepth; k++) begin
         if (rdy[k]) begin
            valid_in[k] = valid_ff[k-1];
         end else begin
            valid_in[k] = valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture the input pixel
   always_comb begin
      pix_in.red   = req_red;
      pix_in.green = req_green;
      pix_in.blue  = req_blue;
   end

   // Prep: max, min, sector, numerators and divisors
   always_comb begin
      logic [7:0]  hi;
      logic [7:0]  lo;
      logic [7:0]  span;
      logic [8:0]  diff;
      logic [7:0]  mag;
      hi = (pix_ff.red > pix_ff.green) ? pix_ff.red : pix_ff.green;
      hi = (hi > pix_ff.blue) ? hi : pix_ff.blue;
      lo = (pix_ff.red < pix_ff.green) ? pix_ff.red : pix_ff.green;
      lo = (lo < pix_ff.blue) ? lo : pix_ff.blue;
      span = hi - lo;
      // Ties: red wins over green, green over blue
      if (hi == pix_ff.red) begin
         prep_in.hue_base = HueRed;
         diff = {1'b0, pix_ff.green} - {1'b0, pix_ff.blue};
      end else if (hi == pix_ff.green) begin
         prep_in.hue_base = HueGreen;
         diff = {1'b0, pix_ff.blue} - {1'b0, pix_ff.red};
      end else begin
         prep_in.hue_base = HueBlue;
         diff = {1'b0, pix_ff.red} - {1'b0, pix_ff.green};
      end
      // Divide the magnitude, restore the sign at the end (truncate to zero)
      prep_in.hue_neg = diff[8];
      mag = diff[8] ? 8'(-diff) : diff[7:0];
      prep_in.hue_rem = 16'(HueGain) * {8'b0, mag};
      prep_in.sat_rem = 16'(SatGain) * {8'b0, span};
      // Black and gray pixels have zero numerators: keep divisors nonzero
      prep_in.hue_den    = (span == 8'd0) ? 8'd1 : span;
      prep_in.sat_den    = (hi == 8'd0) ? 8'd1 : hi;
      prep_in.hue_quo    = '0;
      prep_in.sat_quo    = '0;
      prep_in.brightness = hi;
   end

   // Division: two quotient bits per stage, most significant first
   always_comb begin
      step_type h_step;
      step_type s_step;
      logic [2:0] shamt;
      for (int k = DivFirst; k <= DivLast; k++) begin
         div_in[k] = div_ff[k-1];
         for (int j = 0; j < 2; j++) begin
            shamt  = 3'(11 - 2 * k - j);
            h_step = div_step(div_in[k].hue_rem, div_in[k].hue_den, shamt);
            s_step = div_step(div_in[k].sat_rem, div_in[k].sat_den, shamt);
            div_in[k].hue_rem        = h_step.rem;
            div_in[k].hue_quo[shamt] = h_step.quo_bit;
            div_in[k].sat_rem        = s_step.rem;
            div_in[k].sat_quo[shamt] = s_step.quo_bit;
         end
      end
   end

   // Combine: hue wraps modulo 256
   always_comb begin
      if (div_ff[DivLast].hue_neg) begin
         hue_in = div_ff[DivLast].hue_base - div_ff[DivLast].hue_quo;
      end else begin
         hue_in = div_ff[DivLast].hue_base + div_ff[DivLast].hue_quo;
      end
      sat_in    = div_ff[DivLast].sat_quo;
      bright_in = div_ff[DivLast].brightness;
   end

   // Payload registers: load when the slot takes a new item
   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         pix_ff <= pix_in;
      end
      if (rdy[1]) begin
         div_ff[1] <= prep_in;
      end
      for (int k = DivFirst; k <= DivLast; k++) begin
         if (rdy[k]) begin
            div_ff[k] <= div_in[k];
         end
      end
      if (rdy[PipeDepth-1]) begin
         hue_ff    <= hue_in;
         sat_ff    <= sat_in;
         bright_ff <= bright_in;
      end
   end

   assign rsp_valid      = valid_ff[PipeDepth-1];
   assign rsp_hue        = hue_ff;
   assign rsp_saturation = sat_ff;
   assign rsp_brightness = bright_ff;

endmodule
